@@ rtl/fsrs_pkg.sv @@
package fsrs_pkg;

   // Table size and derived widths
   localparam int MAX_STATES   = 16;
   localparam int STATE_W      = $clog2(MAX_STATES);
   localparam int COUNT_W      = $clog2(MAX_STATES + 1);
   localparam int CNT_DEPTH    = MAX_STATES * MAX_STATES;
   localparam int CNT_ADDR_W   = $clog2(CNT_DEPTH);

   // Field widths
   localparam int OP_W         = 3;
   localparam int FREQ_W       = 32;
   localparam int TIME_W       = 64;
   localparam int CNT_W        = 32;
   localparam int STATUS_W     = 2;
   localparam int CSR_W        = 5;
   localparam int REQ_DATA_W   = 104;
   localparam int RSP_DATA_W   = 72;

   // Operation codes
   localparam logic [OP_W-1:0] OP_LOAD       = 3'd0;
   localparam logic [OP_W-1:0] OP_START      = 3'd1;
   localparam logic [OP_W-1:0] OP_CHANGE     = 3'd2;
   localparam logic [OP_W-1:0] OP_READ_RES   = 3'd3;
   localparam logic [OP_W-1:0] OP_READ_TRANS = 3'd4;
   localparam logic [OP_W-1:0] OP_READ_TOTAL = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

   typedef logic [MAX_STATES-1:0][FREQ_W-1:0] freq_table_type;

   // Control from the pipeline to the transition counter memory
   typedef struct packed {
      logic                  clear;
      logic                  rd_en;
      logic [CNT_ADDR_W-1:0] rd_addr;
      logic                  wr_en;
      logic [CNT_ADDR_W-1:0] wr_addr;
   } cnt_ctl_type;

endpackage

@@ rtl/fsrs_lookup.sv @@
module fsrs_lookup (
   input  fsrs_pkg::freq_table_type       table_entries,
   input  logic [fsrs_pkg::FREQ_W-1:0]    key,
   input  logic [fsrs_pkg::COUNT_W-1:0]   entry_count,
   output logic                           found,
   output logic [fsrs_pkg::STATE_W-1:0]   index
);
   import fsrs_pkg::*;

   logic [MAX_STATES-1:0] hit;

   // Compare every entry in use against the key
   always_comb begin
      for (int i = 0; i < MAX_STATES; i++) begin
         hit[i] = (table_entries[i] == key) && (COUNT_W'(i) < entry_count);
      end
   end

   // Pick the lowest matching entry
   always_comb begin
      found = 1'b0;
      index = '0;
      for (int i = MAX_STATES - 1; i >= 0; i--) begin
         if (hit[i]) begin
            found = 1'b1;
            index = STATE_W'(i);
         end
      end
   end

endmodule

@@ rtl/fsrs_trans_counts.sv @@
module fsrs_trans_counts (
   input  logic                         clock,
   input  logic                         reset,
   input  fsrs_pkg::cnt_ctl_type        ctl,
   input  logic [fsrs_pkg::CNT_W-1:0]   wr_data,
   output logic [fsrs_pkg::CNT_W-1:0]   rd_data
);
   import fsrs_pkg::*;

   logic [CNT_W-1:0]     mem [CNT_DEPTH];
   logic [CNT_DEPTH-1:0] valid_ff;
   logic [CNT_W-1:0]     rd_mem_ff;
   logic                 rd_ok_ff;
   logic                 rd_fwd_ff;
   logic [CNT_W-1:0]     rd_fwd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_data;
      end
   end

   // Entry valid bits; a clear drops every entry at once and wins over a write
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[ctl.wr_addr] <= 1'b1;
      end
   end

   // Registered read, with bypass of a write to the same entry in the same cycle
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_mem_ff      <= mem[ctl.rd_addr];
         rd_fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ok_ff  <= 1'b0;
         rd_fwd_ff <= 1'b0;
      end else if (ctl.rd_en) begin
         rd_ok_ff  <= valid_ff[ctl.rd_addr];
         rd_fwd_ff <= ctl.wr_en && (ctl.wr_addr == ctl.rd_addr);
      end
   end

   // Entries never written since the last clear read as zero
   always_comb begin
      if (rd_fwd_ff) begin
         rd_data = rd_fwd_data_ff;
      end else if (rd_ok_ff) begin
         rd_data = rd_mem_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule

@@ rtl/freq_state_residency_stats_core.sv @@
// Channel  | Ports          | Transfer carries
// ---------+----------------+--------------------------------------------------
// request  | req_t*         | operation in tuser; frequency, now, indexes in tdata
// response | rsp_t*         | status in tuser; read value, state, known in tdata
// register | csr_we/wdata   | number of table entries in use
//
// Each item passes an input stage and a result stage; one item is accepted
// per cycle when the response side takes results.
// The residency table and the current-state bookkeeping settle in the input
// stage; the transition counter memory does its registered read there and its
// increment write-back in the result stage, with a bypass between the two.
// A stalled response holds both stages and drops req_tready.
// Synchronous reset clears all counters, the table and the pipeline at once.
module freq_state_residency_stats_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // operation
   input  logic [fsrs_pkg::OP_W-1:0]            req_tuser,
   // frequency [31:0], now [95:32], first_index [99:96], second_index [103:100]
   input  logic [fsrs_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // status
   output logic [fsrs_pkg::STATUS_W-1:0]        rsp_tuser,
   // read_value [63:0], current_state [67:64], state_known [68], zero [71:69]
   output logic [fsrs_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_we,
   input  logic [fsrs_pkg::CSR_W-1:0]           csr_wdata
);
   import fsrs_pkg::*;

   logic pipe_advance;
   logic s1_fire;

   // Configuration and architectural state
   logic [CSR_W-1:0]   count_ff;
   logic [COUNT_W-1:0] eff_count;
   freq_table_type     freq_ff;
   logic [TIME_W-1:0]  res_ff [MAX_STATES];
   logic [TIME_W-1:0]  pend_ff, pend_in;
   logic [TIME_W-1:0]  prev_ff, prev_in;
   logic [STATE_W-1:0] ps_ff, ps_in;
   logic               pv_ff, pv_in;
   logic [CNT_W-1:0]   total_ff, total_in;

   // Input stage
   logic               s1_valid_ff;
   logic [OP_W-1:0]    s1_op_ff;
   logic [FREQ_W-1:0]  s1_freq_ff;
   logic [TIME_W-1:0]  s1_now_ff;
   logic [STATE_W-1:0] s1_a_ff;
   logic [STATE_W-1:0] s1_b_ff;

   // Result stage
   logic                  s2_valid_ff;
   logic [TIME_W-1:0]     s2_value_ff, s2_value_in;
   logic [STATUS_W-1:0]   s2_status_ff, s2_status_in;
   logic [STATE_W-1:0]    s2_ps_ff;
   logic                  s2_pv_ff;
   logic                  s2_use_cnt_ff, s2_use_cnt_in;
   logic                  s2_inc_ff, s2_inc_in;
   logic [CNT_ADDR_W-1:0] s2_waddr_ff, s2_waddr_in;

   // Input-stage working signals
   logic                  found;
   logic [STATE_W-1:0]    idx;
   logic                  a_in_range, b_in_range;
   logic [TIME_W-1:0]     delta, pend_add, res_rd;
   logic [STATE_W-1:0]    res_sel;
   logic                  res_clear, res_we;
   logic                  freq_we;
   logic                  cnt_clear, cnt_rd;
   logic [CNT_ADDR_W-1:0] cnt_raddr;
   cnt_ctl_type           cnt_ctl;
   logic [CNT_W-1:0]      cnt_rd_data;

   // Move both stages together whenever the result register is free
   assign pipe_advance = !s2_valid_ff || rsp_tready;
   assign req_tready   = pipe_advance;
   assign s1_fire      = pipe_advance && s1_valid_ff;

   assign eff_count  = (COUNT_W'(count_ff) > COUNT_W'(MAX_STATES)) ?
                       COUNT_W'(MAX_STATES) : COUNT_W'(count_ff);
   assign a_in_range = COUNT_W'(s1_a_ff) < eff_count;
   assign b_in_range = COUNT_W'(s1_b_ff) < eff_count;

   fsrs_lookup u_lookup (
      .table_entries (freq_ff),
      .key           (s1_freq_ff),
      .entry_count   (eff_count),
      .found         (found),
      .index         (idx)
   );

   // Elapsed time and the running residency of the present state
   assign delta    = s1_now_ff - prev_ff;
   assign pend_add = pend_ff + delta;
   assign res_sel  = (s1_op_ff == OP_CHANGE) ? idx : s1_a_ff;
   assign res_rd   = res_ff[res_sel];

   // Decode the operation in the input stage
   always_comb begin
      pend_in       = pend_ff;
      prev_in       = prev_ff;
      ps_in         = ps_ff;
      pv_in         = pv_ff;
      total_in      = total_ff;
      s2_value_in   = '0;
      s2_status_in  = ST_OK;
      s2_use_cnt_in = 1'b0;
      s2_inc_in     = 1'b0;
      s2_waddr_in   = {ps_ff, idx};
      res_clear     = 1'b0;
      res_we        = 1'b0;
      freq_we       = 1'b0;
      cnt_clear     = 1'b0;
      cnt_rd        = 1'b0;
      cnt_raddr     = {ps_ff, idx};
      unique case (s1_op_ff)
         OP_LOAD: begin
            if (a_in_range) begin
               freq_we = 1'b1;
            end else begin
               s2_status_in = ST_RANGE;
            end
         end
         OP_START: begin
            res_clear    = 1'b1;
            cnt_clear    = 1'b1;
            total_in     = '0;
            prev_in      = s1_now_ff;
            pend_in      = '0;
            ps_in        = found ? idx : '0;
            pv_in        = found;
            s2_status_in = found ? ST_OK : ST_UNKNOWN;
         end
         OP_CHANGE: begin
            if (!pv_ff || !found) begin
               s2_status_in = ST_UNKNOWN;
            end else begin
               prev_in = s1_now_ff;
               if (idx != ps_ff) begin
                  // fold the old state back into the table, pick up the new one
                  res_we    = 1'b1;
                  pend_in   = res_rd;
                  cnt_rd    = 1'b1;
                  s2_inc_in = 1'b1;
                  total_in  = total_ff + 1'b1;
                  ps_in     = idx;
               end else begin
                  pend_in = pend_add;
               end
            end
         end
         OP_READ_RES: begin
            prev_in = s1_now_ff;
            if (pv_ff) begin
               pend_in = pend_add;
            end
            if (!a_in_range) begin
               s2_status_in = ST_RANGE;
            end else if (pv_ff && (s1_a_ff == ps_ff)) begin
               s2_value_in = pend_add;
            end else begin
               s2_value_in = res_rd;
            end
         end
         OP_READ_TRANS: begin
            if (a_in_range && b_in_range) begin
               cnt_rd        = 1'b1;
               cnt_raddr     = {s1_a_ff, s1_b_ff};
               s2_use_cnt_in = 1'b1;
            end else begin
               s2_status_in = ST_RANGE;
            end
         end
         OP_READ_TOTAL: begin
            s2_value_in = TIME_W'(total_ff);
         end
         default: begin
         end
      endcase
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   // Frequency table
   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= '0;
      end else if (s1_fire && freq_we) begin
         freq_ff[s1_a_ff] <= s1_freq_ff;
      end
   end

   // Residency table
   always_ff @(posedge clock) begin
      if (reset || (s1_fire && res_clear)) begin
         for (int i = 0; i < MAX_STATES; i++) begin
            res_ff[i] <= '0;
         end
      end else if (s1_fire && res_we) begin
         res_ff[ps_ff] <= pend_add;
      end
   end

   // Present state, time stamp and totals
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         prev_ff  <= '0;
         ps_ff    <= '0;
         pv_ff    <= 1'b0;
         total_ff <= '0;
      end else if (s1_fire) begin
         pend_ff  <= pend_in;
         prev_ff  <= prev_in;
         ps_ff    <= ps_in;
         pv_ff    <= pv_in;
         total_ff <= total_in;
      end
   end

   // Input stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pipe_advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance && req_tvalid) begin
         s1_op_ff   <= req_tuser;
         s1_freq_ff <= req_tdata[31:0];
         s1_now_ff  <= req_tdata[95:32];
         s1_a_ff    <= req_tdata[99:96];
         s1_b_ff    <= req_tdata[103:100];
      end
   end

   // Result stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff   <= 1'b0;
         s2_use_cnt_ff <= 1'b0;
         s2_inc_ff     <= 1'b0;
      end else if (pipe_advance) begin
         s2_valid_ff   <= s1_valid_ff;
         s2_use_cnt_ff <= s1_valid_ff && s2_use_cnt_in;
         s2_inc_ff     <= s1_valid_ff && s2_inc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         s2_value_ff  <= s2_value_in;
         s2_status_ff <= s2_status_in;
         s2_ps_ff     <= ps_in;
         s2_pv_ff     <= pv_in;
         s2_waddr_ff  <= s2_waddr_in;
      end
   end

   // Transition counters: read in the input stage, write back as the result leaves
   always_comb begin
      cnt_ctl.clear   = s1_fire && cnt_clear;
      cnt_ctl.rd_en   = s1_fire && cnt_rd;
      cnt_ctl.rd_addr = cnt_raddr;
      cnt_ctl.wr_en   = pipe_advance && s2_valid_ff && s2_inc_ff;
      cnt_ctl.wr_addr = s2_waddr_ff;
   end

   fsrs_trans_counts u_trans_counts (
      .clock   (clock),
      .reset   (reset),
      .ctl     (cnt_ctl),
      .wr_data (cnt_rd_data + 1'b1),
      .rd_data (cnt_rd_data)
   );

   // Response
   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tuser  = s2_status_ff;
   assign rsp_tdata  = {3'b000, s2_pv_ff, s2_ps_ff,
                        s2_use_cnt_ff ? TIME_W'(cnt_rd_data) : s2_value_ff};

endmodule

@@ rtl/fsrs_checker.sv @@
module fsrs_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tready,
   input  logic [fsrs_pkg::STATUS_W-1:0]        rsp_tuser,
   input  logic [fsrs_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready
);
   import fsrs_pkg::*;

   // No result is pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response holds its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // Rejected operations return no value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tdata[63:0] == '0)
      else $error("nonzero value with error status");

   // An unknown state reports index zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[68] |-> rsp_tdata[67:64] == '0)
      else $error("unknown state with nonzero index");

   // Input is held back only by a stalled response
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled without response backpressure");

endmodule

bind freq_state_residency_stats_core fsrs_checker u_fsrs_checker (.*);

@@ tb/freq_state_residency_stats_core_tb.sv @@
module freq_state_residency_stats_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fsrs_pkg::*;

   // Operation codes with no function in the block
   localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

   localparam int HOLD_CYCLES    = 90;
   localparam int SESSION_STEPS  = 155;
   localparam int SETTLE_CYCLES  = 8;

   typedef struct packed {
      logic [TIME_W-1:0]   read_value;
      logic [STATUS_W-1:0] status;
      logic [STATE_W-1:0]  current_state;
      logic                state_known;
   } stats_result_type;

   logic                  clock;
   logic                  reset;
   logic [OP_W-1:0]       req_tuser;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  csr_we;
   logic [CSR_W-1:0]      csr_wdata;

   // Predicted block state
   logic [CSR_W-1:0]  entries_in_use;
   logic [FREQ_W-1:0] tbl_freq [MAX_STATES];
   logic [TIME_W-1:0] res_ticks [MAX_STATES];
   logic [CNT_W-1:0]  trans_cnt [CNT_DEPTH];
   logic [CNT_W-1:0]  trans_total;
   logic [TIME_W-1:0] last_stamp;
   logic [STATE_W-1:0] cur_state;
   logic              cur_known;

   stats_result_type pending_results[$];

   // Run bookkeeping
   bit          idling_on = 1'b1;
   bit          hold_request = 1'b0;
   logic [TIME_W-1:0] stamp = '0;
   int unsigned error_count = 0;
   int unsigned items_sent = 0;
   int unsigned results_checked = 0;
   int unsigned input_stall_cycles = 0;
   int unsigned sizes_run = 0;

   freq_state_residency_stats_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Number of table entries actually searched
   function automatic int unsigned usable_entries();
      return (entries_in_use > MAX_STATES) ? MAX_STATES : entries_in_use;
   endfunction

   // Compute the response of one request and advance the predicted state
   function automatic void predict_stats(input logic [OP_W-1:0] op,
                                         input logic [FREQ_W-1:0] freq,
                                         input logic [TIME_W-1:0] now,
                                         input logic [STATE_W-1:0] a,
                                         input logic [STATE_W-1:0] b);
      int unsigned   limit;
      bit            found;
      logic [STATE_W-1:0] hit;
      stats_result_type r;
      limit = usable_entries();
      r = '0;
      found = 1'b0;
      hit = '0;
      for (int i = 0; i < limit; i++) begin
         if (!found && tbl_freq[i] == freq) begin
            found = 1'b1;
            hit = i[STATE_W-1:0];
         end
      end
      r.status = ST_OK;
      case (op)
         OP_LOAD: begin
            if (a < limit) tbl_freq[a] = freq;
            else r.status = ST_RANGE;
         end
         OP_START: begin
            foreach (res_ticks[i]) res_ticks[i] = '0;
            foreach (trans_cnt[i]) trans_cnt[i] = '0;
            trans_total = '0;
            last_stamp = now;
            cur_state = hit;
            cur_known = found;
            r.status = found ? ST_OK : ST_UNKNOWN;
         end
         OP_CHANGE: begin
            if (!cur_known || !found) begin
               r.status = ST_UNKNOWN;
            end else begin
               res_ticks[cur_state] += now - last_stamp;
               last_stamp = now;
               if (hit != cur_state) begin
                  trans_cnt[{cur_state, hit}] += 1;
                  trans_total += 1;
                  cur_state = hit;
               end
            end
         end
         OP_READ_RES: begin
            // bring the present state's time up to date before the read
            if (cur_known) res_ticks[cur_state] += now - last_stamp;
            last_stamp = now;
            if (a < limit) r.read_value = res_ticks[a];
            else r.status = ST_RANGE;
         end
         OP_READ_TRANS: begin
            if (a < limit && b < limit) r.read_value = {32'd0, trans_cnt[{a, b}]};
            else r.status = ST_RANGE;
         end
         OP_READ_TOTAL: r.read_value = {32'd0, trans_total};
         default: ;
      endcase
      r.current_state = cur_state;
      r.state_known = cur_known;
      pending_results.push_back(r);
   endfunction

   // Offer one request, wait for its transfer, then record the prediction
   task automatic send_item(input logic [OP_W-1:0] op, input logic [FREQ_W-1:0] freq,
                            input logic [TIME_W-1:0] now, input logic [STATE_W-1:0] a,
                            input logic [STATE_W-1:0] b);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= {b, a, now, freq};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      predict_stats(op, freq, now, a, b);
   endtask

   // Drop valid and wait until every predicted response has come back
   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_state_count(input logic [CSR_W-1:0] value);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      entries_in_use = value;
      csr_we <= 1'b0;
   endtask

   // Advance the time stamp, with an occasional jump anywhere
   function automatic logic [TIME_W-1:0] next_stamp();
      if ($urandom_range(0, 39) == 0) stamp = {$urandom, $urandom};
      else stamp += $urandom_range(0, 4000);
      return stamp;
   endfunction

   // Mostly a frequency from the table, sometimes one that is not there
   function automatic logic [FREQ_W-1:0] pick_table_freq();
      int unsigned limit;
      limit = usable_entries();
      if (limit == 0 || $urandom_range(0, 9) == 0) return $urandom;
      return tbl_freq[$urandom_range(0, limit - 1)];
   endfunction

   function automatic logic [STATE_W-1:0] pick_index();
      int unsigned limit;
      limit = usable_entries();
      if (limit == 0 || $urandom_range(0, 7) == 0) return STATE_W'($urandom_range(0, 15));
      return STATE_W'($urandom_range(0, limit - 1));
   endfunction

   // Empty table: every lookup fails and every index is out of range
   task automatic test_empty_table();
      write_state_count(5'd0);
      send_item(OP_LOAD, 32'd1000, 64'd0, 4'd0, 4'd0);
      send_item(OP_READ_RES, 32'd0, 64'd50, 4'd0, 4'd0);
      send_item(OP_CHANGE, 32'd0, 64'd60, 4'd0, 4'd0);
      send_item(OP_UNUSED_A, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 4'hF);
      send_item(OP_UNUSED_B, 32'h1234_5678, 64'd7, 4'd3, 4'd9);
      wait_results_done();
   endtask

   // Four entries with a duplicate, plus a load just past the end
   task automatic test_table_load();
      write_state_count(5'd4);
      send_item(OP_LOAD, 32'd0, 64'd0, 4'd0, 4'd0);
      send_item(OP_LOAD, 32'hFFFF_FFFF, 64'd0, 4'd1, 4'd0);
      send_item(OP_LOAD, 32'd1000, 64'd0, 4'd2, 4'd0);
      send_item(OP_LOAD, 32'd1000, 64'd0, 4'd3, 4'd0);
      send_item(OP_LOAD, 32'd2000, 64'd0, 4'd4, 4'd0);
   endtask

   // Unknown start, known start, changes across a time wrap and to an unknown frequency
   task automatic test_start_and_change();
      send_item(OP_START, 32'd5555, 64'd10, 4'd0, 4'd0);
      send_item(OP_START, 32'hFFFF_FFFF, 64'd100, 4'd0, 4'd0);
      send_item(OP_CHANGE, 32'd0, 64'd250, 4'd0, 4'd0);
      send_item(OP_CHANGE, 32'd1000, 64'hFFFF_FFFF_FFFF_FFF0, 4'd0, 4'd0);
      send_item(OP_CHANGE, 32'd1000, 64'd5, 4'd0, 4'd0);
      send_item(OP_CHANGE, 32'd777, 64'd9, 4'd0, 4'd0);
   endtask

   // Reads in and out of range, then a count above the table size
   task automatic test_reads();
      send_item(OP_READ_RES, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd2, 4'd0);
      send_item(OP_READ_RES, 32'd0, 64'd20, 4'd15, 4'd0);
      send_item(OP_READ_TRANS, 32'd0, 64'd0, 4'd1, 4'd0);
      send_item(OP_READ_TRANS, 32'd0, 64'd0, 4'd0, 4'd15);
      send_item(OP_READ_TRANS, 32'd0, 64'd0, 4'd15, 4'd0);
      send_item(OP_READ_TOTAL, 32'd0, 64'd0, 4'd0, 4'd0);
      wait_results_done();
      write_state_count(5'd31);
      send_item(OP_LOAD, 32'd3000, 64'd0, 4'd15, 4'd0);
      send_item(OP_READ_TRANS, 32'd0, 64'd0, 4'd15, 4'd15);
      wait_results_done();
   endtask

   // Hold the response side for a long stretch while requests keep coming
   task automatic test_backpressure();
      idling_on = 1'b0;
      hold_request = 1'b1;
      send_item(OP_START, pick_table_freq(), next_stamp(), 4'd0, 4'd0);
      repeat (23) begin
         if ($urandom_range(0, 1) == 0)
            send_item(OP_CHANGE, pick_table_freq(), next_stamp(), 4'd0, 4'd0);
         else
            send_item(OP_READ_RES, 32'd0, next_stamp(), pick_index(), pick_index());
      end
      wait_results_done();
      idling_on = 1'b1;
   endtask

   // Sessions at several table sizes: load, start, then mostly changes and reads
   task automatic test_random_sessions();
      int unsigned sizes[10] = '{16, 3, 31, 1, 8, 0, 17, 12, 2, 16};
      int unsigned limit;
      int unsigned pick;
      logic [FREQ_W-1:0] freq;
      foreach (sizes[p]) begin
         // the closing session runs without idling on either side
         if (p == $size(sizes) - 1) idling_on = 1'b0;
         wait_results_done();
         write_state_count(sizes[p][CSR_W-1:0]);
         sizes_run++;
         limit = usable_entries();
         for (int i = 0; i < limit; i++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) freq = 32'd0;
            else if (pick == 1) freq = 32'hFFFF_FFFF;
            else if (pick < 4 && i > 0) freq = tbl_freq[$urandom_range(0, i - 1)];
            else freq = $urandom;
            send_item(OP_LOAD, freq, 64'd0, i[STATE_W-1:0], pick_index());
         end
         send_item(OP_START, pick_table_freq(), next_stamp(), 4'd0, 4'd0);
         repeat (SESSION_STEPS) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
               send_item(OP_CHANGE, pick_table_freq(), next_stamp(), pick_index(), 4'd0);
            else if (pick < 62)
               send_item(OP_READ_RES, $urandom, next_stamp(), pick_index(), pick_index());
            else if (pick < 74)
               send_item(OP_READ_TRANS, $urandom, stamp, pick_index(), pick_index());
            else if (pick < 80)
               send_item(OP_READ_TOTAL, $urandom, stamp, pick_index(), pick_index());
            else if (pick < 85)
               send_item(OP_LOAD, $urandom, stamp, pick_index(), pick_index());
            else if (pick < 89)
               send_item(OP_START, pick_table_freq(), next_stamp(), 4'd0, 4'd0);
            else
               send_item(OP_W'($urandom_range(0, 7)), $urandom, {$urandom, $urandom},
                         STATE_W'($urandom_range(0, 15)), STATE_W'($urandom_range(0, 15)));
         end
      end
   endtask

   // Response side: random stalls, plus one long hold on request
   initial begin : rsp_ready_gen
      logic level;
      int   span;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            level = 1'b0;
            span = HOLD_CYCLES;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            level = 1'b0;
            span = $urandom_range(1, 12);
         end else begin
            level = 1'b1;
            span = $urandom_range(1, 16);
         end
         rsp_tready <= level;
         repeat (span - 1) @(posedge clock);
      end
   end

   // Count cycles in which the block held off a waiting request
   always @(posedge clock) begin
      if (!reset && req_tvalid && !req_tready) input_stall_cycles++;
   end

   // Compare each response transfer with the oldest prediction
   always @(posedge clock) begin : check_responses
      stats_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response: status %0d, data %h", rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_tdata[63:0] !== want.read_value) begin
               $error("read_value: expected %h, got %h", want.read_value, rsp_tdata[63:0]);
               error_count++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[67:64] !== want.current_state) begin
               $error("current_state: expected %0d, got %0d", want.current_state,
                      rsp_tdata[67:64]);
               error_count++;
            end
            if (rsp_tdata[68] !== want.state_known) begin
               $error("state_known: expected %0d, got %0d", want.state_known, rsp_tdata[68]);
               error_count++;
            end
            if (rsp_tdata[71:69] !== 3'd0) begin
               $error("padding: expected 0, got %0d", rsp_tdata[71:69]);
               error_count++;
            end
         end
      end
   end

   // Give up on a hung run
   initial begin
      #4_000_000;
      $display("freq_state_residency_stats_core_tb: errors");
      $finish;
   end

   initial begin
      // predicted state after reset
      entries_in_use = '0;
      foreach (tbl_freq[i]) tbl_freq[i] = '0;
      foreach (res_ticks[i]) res_ticks[i] = '0;
      foreach (trans_cnt[i]) trans_cnt[i] = '0;
      trans_total = '0;
      last_stamp = '0;
      cur_state = '0;
      cur_known = 1'b0;

      reset      = 1'b1;
      req_tuser  = '0;
      req_tdata  = '0;
      req_tvalid = 1'b0;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_table_load();
      test_start_and_change();
      test_reads();
      test_backpressure();
      test_random_sessions();

      wait_results_done();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run sent %0d requests and checked %0d responses across %0d table sizes",
               items_sent, results_checked, sizes_run);
      $display("requests were held off for %0d cycles in total", input_stall_cycles);
      if (error_count == 0)
         $display("freq_state_residency_stats_core_tb: clean");
      else
         $display("freq_state_residency_stats_core_tb: errors");
      $finish;
   end

endmodule
